FILE: hw/rtl/adaptive_riemann_sum_integrator_unit_macros.svh
// Assertion macros for the Riemann sum integrator checker.
// Expects clk and rst in the scope of each use.
`ifndef ADAPTIVE_RIEMANN_SUM_INTEGRATOR_UNIT_MACROS_SVH
`define ADAPTIVE_RIEMANN_SUM_INTEGRATOR_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ARS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication checked in the cycle after the trigger
`define ARS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/ars_pkg.sv
// Shared constants, codes, types and sequencer states for the integrator.
// No dependencies; used by every other file in the block but the macro header.
package ars_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int IN_W          = 24;
  localparam int MAX_INTERVALS = 5000;
  localparam int CNT_W         = 13;
  localparam int SUM_W         = 48;
  localparam int MAG_W         = 47;
  localparam int FVAL_W        = 31;
  localparam int ACC_W         = 44;
  localparam int MUL_W         = 32;
  localparam int PROD_W        = 64;
  localparam int DIVN_W        = 68;
  localparam int DIVD_W        = 40;
  localparam int DIV_CNT_W     = 7;
  localparam int SQ_IN_W       = 40;
  localparam int SQ_OUT_W      = 20;
  localparam int SQ_STEPS      = 20;
  localparam int SQ_CNT_W      = 5;
  localparam int F1_OFFSET     = 3 << FRAC_BITS;

  localparam logic FN_SQUARE = 1'b0;
  localparam logic FN_ROOT   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_CONVERGED   = 2'd0,
    STATUS_LIMIT       = 2'd1,
    STATUS_ROOT_DOMAIN = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DIFF_M,
    ST_DIFF_S,
    ST_AMUL,
    ST_AMUL_R,
    ST_THR_W,
    ST_LOOP_INIT,
    ST_XMUL,
    ST_XDIV,
    ST_XDIV_W,
    ST_FEVAL,
    ST_F_M,
    ST_F_S,
    ST_ACC,
    ST_SLO,
    ST_SHI,
    ST_SADD,
    ST_SDIV,
    ST_SDIV_W,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] operand;
  } sqrt_req_t;

endpackage

FILE: hw/rtl/adaptive_riemann_sum_integrator_unit.sv
// Top level of the Riemann sum integrator: sequencer, shared multiplier, sums.
// Depends on ars_pkg, ars_div and ars_sqrt.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | fn_select, tolerance, upper_limit
//  out     | out_valid / out_stall| interval_count, left_sum, right_sum, status
//
// One item at a time; in_stall is high from acceptance until the result is loaded.
// Each sample point x = i*M/n is formed by the 68-step divider, then f(x) is
// x*x+3 through the shared multiplier or 2*sqrt(x) through ars_sqrt; n+1 points
// plus setup and scaling. Negative root domain: 2. Reset clears the sequencer and
// output valid. A stalled result holds while the next item may still be accepted;
// a finished item waits until the output frees.
module adaptive_riemann_sum_integrator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              fn_select,
  input  logic signed [ars_pkg::IN_W-1:0]   tolerance,
  input  logic signed [ars_pkg::IN_W-1:0]   upper_limit,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [ars_pkg::CNT_W-1:0]  interval_count,
  output logic signed [ars_pkg::SUM_W-1:0]  left_sum,
  output logic signed [ars_pkg::SUM_W-1:0]  right_sum,
  output logic        [1:0]                 status
);
  import ars_pkg::*;

  state_t state, state_next;

  logic               sel;
  logic               lneg;
  logic [IN_W-1:0]    tmag;
  logic [IN_W-1:0]    m;
  logic [FVAL_W-1:0]  diff;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   i;
  logic [IN_W-1:0]    xi;
  logic [FVAL_W-1:0]  fval;
  logic [ACC_W-1:0]   lsum;
  logic [ACC_W-1:0]   rsum;
  logic               side;
  logic [DIVN_W-1:0]  wide;
  logic [MAG_W-1:0]   lmag;
  logic [MAG_W-1:0]   rmag;
  status_t            st;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_res;
  logic [PROD_W-1:0]  prod;
  div_req_t           div_req;
  logic               div_done;
  logic [DIVN_W-1:0]  quo;
  sqrt_req_t          sq_req;
  logic               sq_done;
  logic [SQ_OUT_W-1:0] sq_root;
  logic               accept;
  logic               load_out;
  logic [ACC_W-1:0]   cur_sum;
  logic               sat;
  logic [MAG_W-1:0]   mag;

  ars_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quo)
  );

  ars_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cur_sum  = side ? rsum : lsum;
  assign sat      = |quo[DIVN_W-1:MAG_W+FRAC_BITS];
  assign mag      = sat ? '1 : quo[MAG_W+FRAC_BITS-1:FRAC_BITS];

  // Shared multiplier with registered product
  assign mul_res = mul_a * mul_b;
  always_ff @(posedge clk) begin
    prod <= mul_res;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit requests
  always_comb begin
    state_next       = state;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = DIVN_W'(prod);
    div_req.divisor  = DIVD_W'(n);
    sq_req.start     = 1'b0;
    sq_req.operand   = {m, FRAC_BITS'(0)};
    load_out         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (fn_select == FN_ROOT && upper_limit[IN_W-1]) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        if (sel == FN_SQUARE) begin
          mul_a      = MUL_W'(m);
          mul_b      = MUL_W'(m);
          state_next = ST_DIFF_M;
        end else begin
          sq_req.start = 1'b1;
          state_next   = ST_DIFF_S;
        end
      end
      ST_DIFF_M: state_next = ST_AMUL;
      ST_DIFF_S: begin
        if (sq_done) begin
          state_next = ST_AMUL;
        end
      end
      ST_AMUL: begin
        mul_a      = MUL_W'(m);
        mul_b      = MUL_W'(diff);
        state_next = ST_AMUL_R;
      end
      ST_AMUL_R: begin
        if (tmag == '0) begin
          state_next = ST_LOOP_INIT;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = DIVD_W'(tmag) << FRAC_BITS;
          state_next      = ST_THR_W;
        end
      end
      ST_THR_W: begin
        if (div_done) begin
          state_next = ST_LOOP_INIT;
        end
      end
      ST_LOOP_INIT: state_next = ST_XMUL;
      ST_XMUL: begin
        mul_a      = MUL_W'(i);
        mul_b      = MUL_W'(m);
        state_next = ST_XDIV;
      end
      ST_XDIV: begin
        div_req.start = 1'b1;
        state_next    = ST_XDIV_W;
      end
      ST_XDIV_W: begin
        if (div_done) begin
          state_next = ST_FEVAL;
        end
      end
      ST_FEVAL: begin
        if (sel == FN_SQUARE) begin
          mul_a      = MUL_W'(xi);
          mul_b      = MUL_W'(xi);
          state_next = ST_F_M;
        end else begin
          sq_req.start   = 1'b1;
          sq_req.operand = {xi, FRAC_BITS'(0)};
          state_next     = ST_F_S;
        end
      end
      ST_F_M: state_next = ST_ACC;
      ST_F_S: begin
        if (sq_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: state_next = (i == n) ? ST_SLO : ST_XMUL;
      ST_SLO: begin
        mul_a      = MUL_W'(m);
        mul_b      = cur_sum[MUL_W-1:0];
        state_next = ST_SHI;
      end
      ST_SHI: begin
        mul_a      = MUL_W'(m);
        mul_b      = MUL_W'(cur_sum[ACC_W-1:MUL_W]);
        state_next = ST_SADD;
      end
      ST_SADD: state_next = ST_SDIV;
      ST_SDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = wide;
        state_next       = ST_SDIV_W;
      end
      ST_SDIV_W: begin
        if (div_done) begin
          state_next = side ? ST_DONE : ST_SLO;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Working registers, advanced per state
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          sel  <= fn_select;
          lneg <= upper_limit[IN_W-1];
          tmag <= tolerance[IN_W-1] ? IN_W'(-tolerance) : IN_W'(tolerance);
          m    <= upper_limit[IN_W-1] ? IN_W'(-upper_limit) : IN_W'(upper_limit);
          n    <= CNT_W'(1);
          lmag <= '0;
          rmag <= '0;
          st   <= STATUS_ROOT_DOMAIN;
        end
      end
      ST_DIFF_M: diff <= FVAL_W'(prod >> FRAC_BITS);
      ST_DIFF_S: diff <= FVAL_W'({sq_root, 1'b0});
      ST_AMUL_R: begin
        if (tmag == '0) begin
          n <= CNT_W'(MAX_INTERVALS);
        end
      end
      ST_THR_W: begin
        if (div_done) begin
          n <= (quo < DIVN_W'(MAX_INTERVALS)) ? CNT_W'(quo) + 1'b1
                                              : CNT_W'(MAX_INTERVALS);
        end
      end
      ST_LOOP_INIT: begin
        i    <= '0;
        lsum <= '0;
        rsum <= '0;
        side <= 1'b0;
        st   <= (n == CNT_W'(MAX_INTERVALS)) ? STATUS_LIMIT : STATUS_CONVERGED;
      end
      ST_XDIV_W: begin
        if (div_done) begin
          xi <= quo[IN_W-1:0];
        end
      end
      ST_F_M: fval <= FVAL_W'(prod >> FRAC_BITS) + FVAL_W'(F1_OFFSET);
      ST_F_S: fval <= FVAL_W'({sq_root, 1'b0});
      ST_ACC: begin
        if (i != n) begin
          lsum <= lsum + ACC_W'(fval);
          i    <= i + 1'b1;
        end
        if (i != '0) begin
          rsum <= rsum + ACC_W'(fval);
        end
      end
      ST_SHI: wide <= DIVN_W'(prod);
      ST_SADD: wide <= wide + (DIVN_W'(prod) << MUL_W);
      ST_SDIV_W: begin
        if (div_done) begin
          if (side) begin
            rmag <= mag;
          end else begin
            lmag <= mag;
            side <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      interval_count <= n;
      left_sum       <= lneg ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
      right_sum      <= lneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      status         <= st;
    end
  end

endmodule

FILE: hw/rtl/ars_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ars_pkg for widths and the request struct.
module ars_div (
  input  logic                     clk,
  input  logic                     rst,
  input  ars_pkg::div_req_t        req,
  output logic                     done,
  output logic [ars_pkg::DIVN_W-1:0] quotient
);
  import ars_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVD_W-1:0]    rem;
  logic [DIVD_W-1:0]    divisor_q;
  logic [DIVN_W-1:0]    quo;
  logic [DIVD_W:0]      trial;
  logic [DIVD_W:0]      trial_sub;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign trial     = {rem, quo[DIVN_W-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign fits      = trial >= {1'b0, divisor_q};
  assign quotient  = quo;

  // Control: count the steps, flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIVN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem       <= '0;
      quo       <= req.dividend;
      divisor_q <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo <= {quo[DIVN_W-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/ars_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on ars_pkg for widths and the request struct.
module ars_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  ars_pkg::sqrt_req_t          req,
  output logic                        done,
  output logic [ars_pkg::SQ_OUT_W-1:0] root
);
  import ars_pkg::*;

  logic                busy;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_IN_W-1:0]  v;
  logic [SQ_IN_W-1:0]  res;
  logic [SQ_IN_W-1:0]  bitw;
  logic [SQ_IN_W:0]    trial;
  logic                ge;

  assign trial = {1'b0, res} + {1'b0, bitw};
  assign ge    = {1'b0, v} >= trial;
  assign root  = res[SQ_OUT_W-1:0];

  // Control: fixed step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= SQ_CNT_W'(SQ_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SQ_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one result bit per step, highest even weight first
  always_ff @(posedge clk) begin
    if (req.start) begin
      v    <= req.operand;
      res  <= '0;
      bitw <= SQ_IN_W'(1) << (SQ_IN_W - 2);
    end else if (busy) begin
      if (ge) begin
        v   <= v - trial[SQ_IN_W-1:0];
        res <= (res >> 1) + bitw;
      end else begin
        res <= res >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

endmodule

FILE: hw/rtl/ars_checker.sv
// Port-level checks on the integrator channels, bound to the top level.
// Depends on ars_pkg and the assertion macro header.
`include "adaptive_riemann_sum_integrator_unit_macros.svh"

module ars_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic        [ars_pkg::CNT_W-1:0]  interval_count,
  input logic signed [ars_pkg::SUM_W-1:0]  left_sum,
  input logic signed [ars_pkg::SUM_W-1:0]  right_sum,
  input logic        [1:0]                 status
);
  import ars_pkg::*;

  // Stall the input once an item has been taken
  `ARS_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "input not stalled after accept")

  // Hold a stalled item
  `ARS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_sum) && $stable(right_sum) && $stable(interval_count) && $stable(status), "stalled item changed")

  // Root domain error carries one interval and zero sums
  `ARS_ASSERT_IMPL(a_root_dom, out_valid && status == STATUS_ROOT_DOMAIN, interval_count == CNT_W'(1) && left_sum == '0 && right_sum == '0, "bad root domain item")

  // Convergence happens strictly below the interval limit
  `ARS_ASSERT_IMPL(a_conv_n, out_valid && status == STATUS_CONVERGED, interval_count != '0 && interval_count < CNT_W'(MAX_INTERVALS), "converged count out of range")

  // Limit status only at the interval limit
  `ARS_ASSERT_IMPL(a_limit_n, out_valid && status == STATUS_LIMIT, interval_count == CNT_W'(MAX_INTERVALS), "limit status with wrong count")

endmodule

bind adaptive_riemann_sum_integrator_unit ars_checker u_ars_checker (.*);
